// ===== rtl/dvd_pkg.sv =====
package dvd_pkg;

    // Width of the value field on both channels.
    localparam int DATA_W     = 16;
    // Address width of the mark store; values agreeing in these low bits are equal.
    localparam int VALUE_BITS = 16;
    // Width of the set tag kept beside the marks of every entry.
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [VALUE_BITS-1:0] mark_addr_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic                  seen;
        logic                  reported;
    } mark_entry_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] dup_value;
        logic                     found;
        logic                     end_of_set;
    } result_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctl_state_t;

endpackage

// ===== rtl/dvd_out_fifo.sv =====
module dvd_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dvd_pkg::result_t      push_data,
    input  logic                  pop_ready,
    output logic                  out_valid,
    output dvd_pkg::result_t      out_data,
    output logic [dvd_pkg::FIFO_AW:0] count
);
    import dvd_pkg::*;

    result_t              store [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = store[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/duplicate_value_detector.sv =====
// Duplicate value detector. Each input item carries one signed 16-bit value,
// with tlast marking the final value of a set. The first arrival of a value
// only marks it as seen; its second arrival produces one result item with
// tuser (found) high and the value on tdata; further repeats are silent. The
// last item of a set always produces a result item with tlast high, carrying
// found and the value when that item is itself a new duplicate, and zero data
// otherwise. Results leave in order of detection. Once running, the block
// takes one item per clock cycle, each item costing one read and one write of
// the mark store, with a forwarding path covering back-to-back hits on the
// same entry. s_tready also drops while the four-entry result queue, together
// with the item in flight, has no room for a further item. Marks are tagged
// with an 8-bit set number instead of being wiped at every set end, so a new
// set starts at once; the store must however be swept clean after reset and
// after every 256th set, a pass over all 65536 entries during which s_tready
// stays low. After reset the stall is the pass alone; after the 256th set it
// also covers the write-back of the set's last item, which comes before the
// pass begins. Items already accepted still drain to the result channel
// during that time.
module duplicate_value_detector (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel. s_tdata: bits 15:0 value (signed).
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic signed [dvd_pkg::DATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    // Result channel. m_tdata: bits 15:0 dup_value (signed).
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic signed [dvd_pkg::DATA_W-1:0] m_tdata,
    // m_tuser: bit 0 found.
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import dvd_pkg::*;

    // Mark store: one entry per possible index, set tag plus two marks.
    mark_entry_t mark_mem [2**VALUE_BITS];
    mark_entry_t rd_data_reg;

    ctl_state_t  state_reg, state_next;
    mark_addr_t  clr_addr_reg, clr_addr_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;

    // Second stage: the item whose read was issued in the previous cycle.
    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic                     s1_last_reg;
    mark_addr_t               s1_idx_reg;

    // Last write made by an item, for the read that overlapped with it.
    logic        fwd_valid_reg;
    mark_addr_t  fwd_addr_reg;
    mark_entry_t fwd_data_reg;

    mark_addr_t  s_idx;
    logic        accept;
    logic        wrap_pending;
    logic        fifo_room;
    logic [FIFO_AW:0] fifo_count;

    mark_entry_t cur_entry;
    logic        live, was_seen, was_reported, newly;
    mark_entry_t new_entry;

    logic        mem_we;
    mark_addr_t  mem_waddr;
    mark_entry_t mem_wdata;

    logic        res_push;
    result_t     res_data;
    result_t     out_data;

    assign s_idx = VALUE_BITS'($unsigned(s_tdata));

    // A set end that would wrap the tag must be seen by the sweep before any
    // further item reads the store.
    assign wrap_pending = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_MAX);
    assign fifo_room    = ((FIFO_AW+1)'(fifo_count) + (FIFO_AW+1)'(s1_valid_reg))
                          < (FIFO_AW+1)'(FIFO_DEPTH);
    assign s_tready     = (state_reg == ST_RUN) && fifo_room && !wrap_pending;
    assign accept       = s_tvalid && s_tready;

    // Mark update for the item in the second stage.
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg)) begin
            cur_entry = fwd_data_reg;
        end else begin
            cur_entry = rd_data_reg;
        end
        live         = (cur_entry.epoch == epoch_reg);
        was_seen     = live && cur_entry.seen;
        was_reported = live && cur_entry.reported;
        newly        = was_seen && !was_reported;

        new_entry.epoch    = epoch_reg;
        new_entry.seen     = 1'b1;
        new_entry.reported = was_seen;

        res_push            = s1_valid_reg && (newly || s1_last_reg);
        res_data.dup_value  = newly ? s1_value_reg : '0;
        res_data.found      = newly;
        res_data.end_of_set = s1_last_reg;
    end

    // Control: sweep after reset and on tag wrap, otherwise run.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        mem_we        = 1'b0;
        mem_waddr     = s1_idx_reg;
        mem_wdata     = new_entry;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                epoch_next    = '0;
                if (clr_addr_reg == {VALUE_BITS{1'b1}}) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                mem_we = s1_valid_reg;
                if (s1_valid_reg && s1_last_reg) begin
                    epoch_next = epoch_reg + 1'b1;
                    if (epoch_reg == EPOCH_MAX) begin
                        state_next    = ST_CLEAR;
                        clr_addr_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg <= s_tdata;
            s1_last_reg  <= s_tlast;
            s1_idx_reg   <= s_idx;
        end
        fwd_addr_reg <= s1_idx_reg;
        fwd_data_reg <= new_entry;
    end

    // Mark store: one read and one write port, read data registered.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mark_mem[s_idx];
    end

    dvd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = out_data.dup_value;
    assign m_tuser = out_data.found;
    assign m_tlast = out_data.end_of_set;

endmodule

// ===== rtl/dvd_checker.sv =====
module dvd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic signed [dvd_pkg::DATA_W-1:0] m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);

    // The store is swept after reset, so no item is taken straight away.
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("input accepted or result shown right after reset");

    // A result without a new duplicate can only be a set end.
    a_plain_result_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("result without found or end of set");

    // Data carries zero unless a duplicate is reported.
    a_plain_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-zero data on a result without found");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind duplicate_value_detector dvd_checker u_dvd_checker (.*);

// ===== tb/tb.sv =====
module tb;

    import dvd_pkg::*;

    // Longest stretch the result side holds off, and the run-time guard.
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1500;
    // Enough sets that the block's set numbering wraps and the store is swept again mid-run.
    localparam int MIN_SETS     = 300;
    localparam int PRINT_CAP    = 20;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } set_item_t;

    // Stall patterns on the result side.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } rx_pattern_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [DATA_W-1:0] m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;

    duplicate_value_detector u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Items waiting to be offered; the front is always the one on the bus.
    set_item_t pending_items[$];
    // Results the block owes us, oldest first.
    result_t   dup_reports_q[$];

    // Our own copy of the mark stores. An absent key means the mark is clear,
    // so clearing at the end of a set is simply a delete of both arrays.
    bit seen_marks[int];
    bit reported_marks[int];

    int error_count     = 0;
    int items_queued    = 0;
    int sets_queued     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int dups_checked    = 0;
    int long_holds      = 0;
    int cycle_count     = 0;

    // Handshake seen at the last rising edge, read by the driver at the falling edge.
    bit item_taken = 1'b0;

    // Sender burst and gap bookkeeping.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pattern bookkeeping.
    rx_pattern_t rx_mode    = RX_FREE;
    int          rx_left    = 0;
    int          hold_left  = 0;
    int          hold_at[2] = '{100, 700};

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_item(input logic signed [DATA_W-1:0] value, input logic last);
        set_item_t it;
        it.value = value;
        it.last  = last;
        pending_items.push_back(it);
        items_queued++;
        if (last)
            sets_queued++;
    endtask

    // Works out what one accepted item makes the block report. The store is
    // indexed by the low VALUE_BITS bits of the value, taken as unsigned.
    function automatic void track_duplicate(input logic signed [DATA_W-1:0] value,
                                            input logic last);
        int      idx;
        bit      newly;
        result_t rpt;
        idx   = int'({{(32-DATA_W){1'b0}}, value}) & ((1 << VALUE_BITS) - 1);
        newly = 1'b0;
        if (seen_marks.exists(idx)) begin
            if (!reported_marks.exists(idx)) begin
                reported_marks[idx] = 1'b1;
                newly = 1'b1;
            end
        end else begin
            seen_marks[idx] = 1'b1;
        end
        if (last) begin
            seen_marks.delete();
            reported_marks.delete();
        end
        if (newly || last) begin
            rpt.dup_value  = newly ? value : '0;
            rpt.found      = newly;
            rpt.end_of_set = last;
            dup_reports_q.push_back(rpt);
        end
    endfunction

    // A value drawn either from the corners of the range or at random.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] corners[5];
        corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 4)];
        return DATA_W'($urandom);
    endfunction

    // Cycle counter and overall guard against a hung block.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, dup_reports_q.size());
            $display("duplicate_value_detector verification failed");
            $finish;
        end
    end

    // Monitor: takes every handshake at the rising edge, before the block's
    // own updates of that edge become visible.
    always @(posedge aclk) begin
        result_t exp_rpt;
        if (aresetn) begin
            item_taken = s_tvalid && s_tready;
            if (item_taken) begin
                track_duplicate(s_tdata, s_tlast);
                void'(pending_items.pop_front());
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (dup_reports_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item data=%0d found=%b last=%b",
                                              m_tdata, m_tuser, m_tlast));
                end else begin
                    exp_rpt = dup_reports_q.pop_front();
                    if (exp_rpt.found)
                        dups_checked++;
                    if (m_tdata !== exp_rpt.dup_value)
                        report_mismatch($sformatf("dup_value %0d, expected %0d",
                                                  m_tdata, exp_rpt.dup_value));
                    if (m_tuser !== exp_rpt.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  m_tuser, exp_rpt.found));
                    if (m_tlast !== exp_rpt.end_of_set)
                        report_mismatch($sformatf("end_of_set %b, expected %b",
                                                  m_tlast, exp_rpt.end_of_set));
                end
            end
        end
    end

    // Driver: offers the front of the pending queue in bursts with gaps in
    // between. An item once offered stays on the bus until it is taken.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !item_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items[0].value;
                s_tlast  <= pending_items[0].last;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // A third of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: wanders between free-flowing, random and sparse acceptance,
    // and twice holds off for a long stretch so that the result queue fills
    // and the block has to push back on its input.
    always @(negedge aclk) begin
        if (hold_left == 0 && long_holds < 2 && results_checked >= hold_at[long_holds]) begin
            hold_left = LONG_HOLD;
            long_holds++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_pattern_t'($urandom_range(0, 2));
                rx_left = $urandom_range(5, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= $urandom_range(0, 1);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        int                       set_len;
        int                       pool_len;
        int                       kind;
        logic signed [DATA_W-1:0] pool[8];
        logic signed [DATA_W-1:0] v;

        // Directed sets. A set of one element reports nothing found.
        queue_item(16'sh0000, 1'b1);
        // Both extremes repeated: each is reported on its second arrival only,
        // and a silent repeat as the last item still closes the set.
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7FFF, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7FFF, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7FFF, 1'b1);
        // The last item is itself a new duplicate.
        queue_item(16'sh0001, 1'b0);
        queue_item(16'shFFFF, 1'b0);
        queue_item(16'sh0001, 1'b0);
        queue_item(16'shFFFF, 1'b1);
        // Back-to-back hits on one entry exercise the forwarding path.
        queue_item(16'sh0007, 1'b0);
        queue_item(16'sh0007, 1'b0);
        queue_item(16'sh0007, 1'b0);
        queue_item(16'sh0007, 1'b0);
        queue_item(16'sh5555, 1'b1);
        // Marks must not survive the end of a set.
        queue_item(16'sh8000, 1'b1);
        // Alternating pair, so every bit of the value takes both levels.
        queue_item(16'sh5555, 1'b0);
        queue_item(16'shAAAA, 1'b0);
        queue_item(16'sh5555, 1'b0);
        queue_item(16'shAAAA, 1'b0);
        queue_item(16'sh5555, 1'b1);

        // Random sets: mostly values drawn from a small per-set pool so that
        // duplicates are common, with some noise values mixed in. Many sets
        // are short so that the run passes the point where the block sweeps
        // its store again.
        while (items_queued < RANDOM_ITEMS || sets_queued < MIN_SETS) begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                set_len = $urandom_range(1, 3);
            else if (kind < 96)
                set_len = $urandom_range(4, 12);
            else
                set_len = $urandom_range(20, 40);
            pool_len = $urandom_range(1, 8);
            foreach (pool[i])
                pool[i] = pick_value();
            for (int n = 0; n < set_len; n++) begin
                if ($urandom_range(0, 99) < 15)
                    v = DATA_W'($urandom);
                else
                    v = pool[$urandom_range(0, pool_len - 1)];
                queue_item(v, n == set_len - 1);
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The block sweeps its store after reset before taking anything;
        // the cycle guard covers that wait as well.
        while (pending_items.size() != 0 || dup_reports_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d items in %0d sets, checked %0d results of which %0d were duplicates.",
                 items_accepted, sets_queued, results_checked, dups_checked);
        $display("The result side held off for %0d cycles on %0d occasions.",
                 LONG_HOLD, long_holds);
        if (error_count == 0) begin
            $display("duplicate_value_detector verification clean");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("duplicate_value_detector verification failed");
        end
        $finish;
    end

endmodule
